// ===== design/fra_pkg.sv =====
package fra_pkg;

   // sizes of the store
   localparam int MAX_ENTRIES = 8;
   localparam int IDX_BITS    = 3;
   localparam int CNT_BITS    = 4;
   localparam int KEY_BITS    = 32;
   localparam int VALUE_BITS  = 32;
   localparam int TYPE_BITS   = 2;

   // request kinds
   typedef enum logic [TYPE_BITS-1:0] {
      OP_PUT   = 2'd0,
      OP_GET   = 2'd1,
      OP_WRITE = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   // request payload
   typedef struct packed {
      logic [TYPE_BITS-1:0]   req_type;
      logic [KEY_BITS-1:0]    req_key;
      logic [VALUE_BITS-1:0]  req_value;
   } req_type;

   // result payload
   typedef struct packed {
      logic                   status;
      logic [VALUE_BITS-1:0]  read_value;
      logic                   replaced_oldest;
      logic [CNT_BITS-1:0]    entries_held;
   } rsp_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load;
      logic compare;
      logic shift;
      logic append;
      logic write_hit;
      logic respond;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic                 hit;
      logic                 full;
      logic [TYPE_BITS-1:0] op;
   } stat_type;

   // clamp the configured capacity into 1..MAX_ENTRIES
   function automatic logic [CNT_BITS-1:0] eff_capacity(input logic [CNT_BITS-1:0] cap);
      logic [CNT_BITS-1:0] c;
      c = cap;
      if (c == '0) begin
         c = CNT_BITS'(1);
      end
      if (c > CNT_BITS'(MAX_ENTRIES)) begin
         c = CNT_BITS'(MAX_ENTRIES);
      end
      return c;
   endfunction

endpackage

// ===== design/fra_ctrl.sv =====
module fra_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  fra_pkg::stat_type  stat,
   output fra_pkg::cmd_type   cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOOKUP,
      S_EXEC
   } state_type;

   state_type state_ff;
   state_type state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            cmd.compare = 1'b1;
            state_in    = S_EXEC;
         end
         S_EXEC: begin
            priority if (stat.op == fra_pkg::OP_PUT && !stat.hit && stat.full) begin
               // drop the oldest entry, then check fullness again
               cmd.shift = 1'b1;
            end else if (stat.op == fra_pkg::OP_PUT && !stat.hit) begin
               cmd.append  = 1'b1;
               cmd.respond = 1'b1;
               state_in    = S_IDLE;
            end else if ((stat.op == fra_pkg::OP_PUT || stat.op == fra_pkg::OP_WRITE)
                         && stat.hit) begin
               cmd.write_hit = 1'b1;
               cmd.respond   = 1'b1;
               state_in      = S_IDLE;
            end else begin
               cmd.respond = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

// ===== design/fra_dpath.sv =====
module fra_dpath (
   input  logic                            clock,
   input  logic                            reset,
   input  fra_pkg::req_type                req_payload,
   input  logic                            csr_valid,
   input  logic [fra_pkg::CNT_BITS-1:0]    csr_data,
   input  fra_pkg::cmd_type                cmd,
   output fra_pkg::stat_type               stat,
   output fra_pkg::rsp_type                rsp_payload,
   output logic                            rsp_strobe
);

   fra_pkg::req_type                 req_ff;
   logic [fra_pkg::KEY_BITS-1:0]     key_ff [fra_pkg::MAX_ENTRIES];
   logic [fra_pkg::VALUE_BITS-1:0]   val_ff [fra_pkg::MAX_ENTRIES];
   logic [fra_pkg::CNT_BITS-1:0]     fill_ff;
   logic [fra_pkg::CNT_BITS-1:0]     fill_in;
   logic [fra_pkg::CNT_BITS-1:0]     cap_ff;
   logic [fra_pkg::CNT_BITS-1:0]     cap_eff;
   logic                             hit_ff;
   logic [fra_pkg::IDX_BITS-1:0]     slot_ff;
   logic                             evict_ff;
   fra_pkg::rsp_type                 rsp_ff;
   fra_pkg::rsp_type                 rsp_in;
   logic                             rsp_valid_ff;
   logic                             hit_in;
   logic [fra_pkg::IDX_BITS-1:0]     slot_in;
   logic                             is_get;
   logic                             is_wr;

   assign cap_eff = fra_pkg::eff_capacity(cap_ff);

   // parallel key compare, lowest matching slot wins
   always_comb begin
      hit_in  = 1'b0;
      slot_in = '0;
      for (int i = fra_pkg::MAX_ENTRIES - 1; i >= 0; i--) begin
         if (fra_pkg::CNT_BITS'(i) < fill_ff && key_ff[i] == req_ff.req_key) begin
            hit_in  = 1'b1;
            slot_in = fra_pkg::IDX_BITS'(i);
         end
      end
   end

   assign stat.hit  = hit_ff;
   assign stat.full = (fill_ff >= cap_eff);
   assign stat.op   = req_ff.req_type;

   // entry count after this step
   always_comb begin
      priority if (cmd.shift) begin
         fill_in = fill_ff - fra_pkg::CNT_BITS'(1);
      end else if (cmd.append) begin
         fill_in = fill_ff + fra_pkg::CNT_BITS'(1);
      end else begin
         fill_in = fill_ff;
      end
   end

   // result fields
   assign is_get = (req_ff.req_type == fra_pkg::OP_GET);
   assign is_wr  = (req_ff.req_type == fra_pkg::OP_WRITE);
   always_comb begin
      rsp_in.status          = (is_get || is_wr) && !hit_ff;
      rsp_in.read_value      = (is_get && hit_ff) ? val_ff[slot_ff] : '0;
      rsp_in.replaced_oldest = evict_ff;
      rsp_in.entries_held    = fill_in;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         cap_ff       <= fra_pkg::CNT_BITS'(3);
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         rsp_valid_ff <= cmd.respond;
         if (csr_valid) begin
            cap_ff <= csr_data;
         end
      end
   end

   // request, lookup and result registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff   <= req_payload;
         evict_ff <= 1'b0;
      end
      if (cmd.compare) begin
         hit_ff  <= hit_in;
         slot_ff <= slot_in;
      end
      if (cmd.shift) begin
         evict_ff <= 1'b1;
      end
      if (cmd.respond) begin
         rsp_ff <= rsp_in;
      end
   end

   // entry store: shift toward slot zero, append at the tail, update in place
   always_ff @(posedge clock) begin
      if (cmd.shift) begin
         for (int i = 0; i < fra_pkg::MAX_ENTRIES - 1; i++) begin
            key_ff[i] <= key_ff[i + 1];
            val_ff[i] <= val_ff[i + 1];
         end
      end
      if (cmd.append) begin
         key_ff[fill_ff[fra_pkg::IDX_BITS-1:0]] <= req_ff.req_key;
         val_ff[fill_ff[fra_pkg::IDX_BITS-1:0]] <= req_ff.req_value;
      end
      if (cmd.write_hit) begin
         val_ff[slot_ff] <= req_ff.req_value;
      end
   end

   assign rsp_payload = rsp_ff;
   assign rsp_strobe  = rsp_valid_ff;

endmodule

// ===== design/fifo_replacement_assoc_cache.sv =====
// Eight-entry fully associative key-value store with oldest-first replacement.
// A request is taken when start is high and busy is low. Get, write-existing, a
// put that hits and a put into a store below capacity pass through accept, key
// compare and update before the next request is accepted; a put of a new key
// into a full store first shifts the store down one slot per cycle, dropping the
// oldest entry, until below capacity. The result appears on rsp_payload with
// rsp_strobe high for exactly one cycle, the cycle after the update, and must be
// taken then: there is no way to hold it off. The capacity register may be written
// through csr_* at any time the block is not busy and no result is pending.
module fifo_replacement_assoc_cache (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  fra_pkg::req_type              req_payload,
   output fra_pkg::rsp_type              rsp_payload,
   output logic                          rsp_strobe,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [fra_pkg::CNT_BITS-1:0]  csr_data
);

   fra_pkg::cmd_type   cmd;
   fra_pkg::stat_type  stat;

   assign csr_ready = 1'b1;

   // sequencer
   fra_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // entry store and compare
   fra_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_valid   (csr_valid),
      .csr_data    (csr_data),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_payload (rsp_payload),
      .rsp_strobe  (rsp_strobe)
   );

endmodule
